// ===== rtl/lcdw_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdw_pkg
// Shared types and constants for the 4-bit character LCD write sequencer.
// ----------------------------------------------------------------------------
package lcdw_pkg;

   // Request kinds
   localparam logic [2:0] REQ_COMMAND = 3'd0;
   localparam logic [2:0] REQ_DATA    = 3'd1;
   localparam logic [2:0] REQ_NUMBER  = 3'd2;
   localparam logic [2:0] REQ_CURSOR  = 3'd3;
   localparam logic [2:0] REQ_INIT    = 3'd4;

   localparam int DEFAULT_MAX_DIGITS  = 10;
   localparam int DEFAULT_QUEUE_DEPTH = 4;

   localparam logic [4:0]  INIT_WAIT_MS = 5'd20;
   localparam logic [4:0]  STEP_MS      = 5'd1;
   localparam logic [7:0]  DDRAM_SET    = 8'h80;
   localparam logic [7:0]  ASCII_ZERO   = 8'd48;
   localparam logic [2:0]  INIT_CMD_COUNT = 3'd6;

   // floor(x / 10) == (x * RECIP_10) >> RECIP_SHIFT for every 32-bit x
   localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;

   // One byte job handed from the front end to the pin sequencer
   typedef struct packed {
      logic       wait_job;   // single 20 ms power-up wait snapshot
      logic       reg_sel;
      logic [7:0] byte_val;
      logic       last;       // final job of the request
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic logic [7:0] row_base(input logic [1:0] row);
      logic [7:0] base;
      case (row)
         2'd0:    base = 8'h80;
         2'd1:    base = 8'hC0;
         2'd2:    base = 8'h94;
         default: base = 8'hD4;
      endcase
      return base;
   endfunction

   // Power-up command list, index 0..5
   function automatic logic [7:0] init_cmd(input logic [2:0] idx);
      logic [7:0] cmd;
      case (idx)
         3'd0:    cmd = 8'h33;
         3'd1:    cmd = 8'h32;
         3'd2:    cmd = 8'h28;
         3'd3:    cmd = 8'h0C;
         3'd4:    cmd = 8'h01;
         default: cmd = 8'h06;
      endcase
      return cmd;
   endfunction

endpackage

// ===== rtl/lcdw_front.sv =====
// ----------------------------------------------------------------------------
// lcdw_front
// Accepts requests, classifies them and pushes byte jobs into the queue.
// Converts numbers to decimal digits with a reciprocal multiply by ten.
// ----------------------------------------------------------------------------
module lcdw_front import lcdw_pkg::*; #(
   parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [2:0]   req_type,
   input  logic [7:0]   req_byte_value,
   input  logic [31:0]  req_number_value,
   input  logic [1:0]   req_row_index,
   input  logic [5:0]   req_column_index,
   output logic         push_valid,
   output job_type      push_data,
   input  q_status_type q_status
);

   localparam int CNT_W = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SINGLE,
      ST_MUL,
      ST_DIGIT,
      ST_EMIT,
      ST_INIT
   } state_type;

   state_type        state_ff;
   job_type          job_ff;
   logic [31:0]      num_ff;
   logic [63:0]      prod_ff;
   logic [3:0]       digit_ff [MAX_DIGITS];
   logic [CNT_W-1:0] cnt_ff;
   logic [IDX_W-1:0] pos_ff;
   logic [2:0]       init_idx_ff;

   logic [31:0] quot;
   logic [31:0] rem_full;
   logic        push_go;
   logic        more_digits;

   assign quot     = {3'b000, prod_ff[63:RECIP_SHIFT]};
   assign rem_full = num_ff - ((quot << 3) + (quot << 1));
   assign more_digits = (quot != 32'd0) && ((cnt_ff + CNT_W'(1)) < CNT_W'(MAX_DIGITS));

   assign req_ready = (state_ff == ST_IDLE);
   assign push_go   = push_valid && !q_status.full;

   always_comb begin
      push_valid = 1'b0;
      push_data  = job_ff;
      unique case (state_ff)
         ST_SINGLE: begin
            push_valid = 1'b1;
         end
         ST_EMIT: begin
            push_valid         = 1'b1;
            push_data.wait_job = 1'b0;
            push_data.reg_sel  = 1'b1;
            push_data.byte_val = ASCII_ZERO + {4'b0000, digit_ff[pos_ff]};
            push_data.last     = (pos_ff == '0);
         end
         ST_INIT: begin
            push_valid         = 1'b1;
            push_data.wait_job = (init_idx_ff == 3'd0);
            push_data.reg_sel  = 1'b0;
            push_data.byte_val = init_cmd(init_idx_ff - 3'd1);
            push_data.last     = (init_idx_ff == INIT_CMD_COUNT);
         end
         default: begin
            push_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  job_ff.wait_job <= 1'b0;
                  job_ff.last     <= 1'b1;
                  cnt_ff          <= '0;
                  init_idx_ff     <= 3'd0;
                  num_ff          <= req_number_value;
                  case (req_type)
                     REQ_COMMAND, REQ_DATA: begin
                        job_ff.reg_sel  <= req_type[0];
                        job_ff.byte_val <= req_byte_value;
                        state_ff        <= ST_SINGLE;
                     end
                     REQ_CURSOR: begin
                        job_ff.reg_sel  <= 1'b0;
                        job_ff.byte_val <= (row_base(req_row_index)
                                           + {2'b00, req_column_index}) | DDRAM_SET;
                        state_ff        <= ST_SINGLE;
                     end
                     REQ_NUMBER: state_ff <= ST_MUL;
                     REQ_INIT:   state_ff <= ST_INIT;
                     default:    state_ff <= ST_IDLE;   // unused kinds: drop
                  endcase
               end
            end
            ST_SINGLE: begin
               if (push_go) state_ff <= ST_IDLE;
            end
            ST_MUL: begin
               prod_ff  <= {32'd0, num_ff} * {32'd0, RECIP_10};
               state_ff <= ST_DIGIT;
            end
            ST_DIGIT: begin
               digit_ff[cnt_ff[IDX_W-1:0]] <= rem_full[3:0];
               num_ff <= quot;
               cnt_ff <= cnt_ff + CNT_W'(1);
               pos_ff <= cnt_ff[IDX_W-1:0];
               state_ff <= more_digits ? ST_MUL : ST_EMIT;
            end
            ST_EMIT: begin
               if (push_go) begin
                  if (pos_ff == '0) state_ff <= ST_IDLE;
                  else              pos_ff   <= pos_ff - IDX_W'(1);
               end
            end
            ST_INIT: begin
               if (push_go) begin
                  if (init_idx_ff == INIT_CMD_COUNT) state_ff    <= ST_IDLE;
                  else                               init_idx_ff <= init_idx_ff + 3'd1;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/lcdw_queue.sv =====
// ----------------------------------------------------------------------------
// lcdw_queue
// Short job queue between the front end and the pin sequencer.
// ----------------------------------------------------------------------------
module lcdw_queue import lcdw_pkg::*; #(
   parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   input  job_type      push_data,
   input  logic         pop,
   output job_type      head,
   output q_status_type q_status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type          entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push;
   logic             do_pop;

   assign q_status.full  = (count_ff == CNT_W'(DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push = push_valid && !q_status.full;
   assign do_pop  = pop && !q_status.empty;
   assign head    = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) entries_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + CNT_W'(1);
            2'b01:   count_ff <= count_ff - CNT_W'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// ===== rtl/lcdw_back.sv =====
// ----------------------------------------------------------------------------
// lcdw_back
// Pin sequencer: expands each byte job into timed pin snapshots and holds
// them in the result register.
// ----------------------------------------------------------------------------
module lcdw_back import lcdw_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  job_type      head,
   input  q_status_type q_status,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic         rsp_reg_select,
   output logic         rsp_enable_pin,
   output logic [3:0]   rsp_data_nibble,
   output logic [4:0]   rsp_hold_ms,
   output logic         rsp_last_flag
);

   localparam logic [2:0] LAST_STEP = 3'd4;

   job_type    job_ff;
   logic [2:0] step_ff;
   logic       busy_ff;
   logic       rsp_valid_ff;

   logic       load;
   job_type    src;
   logic [2:0] stp;
   logic       final_snap;

   assign load = !rsp_valid_ff || rsp_ready;
   assign pop  = load && !busy_ff && !q_status.empty;
   assign src  = busy_ff ? job_ff : head;
   assign stp  = busy_ff ? step_ff : 3'd0;
   assign final_snap = src.wait_job || (stp == LAST_STEP);
   assign rsp_valid  = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= busy_ff || !q_status.empty;
         if (busy_ff || !q_status.empty) begin
            job_ff  <= src;
            step_ff <= stp + 3'd1;
            busy_ff <= !final_snap;
            rsp_last_flag <= final_snap && src.last;
            if (src.wait_job) begin
               rsp_reg_select  <= 1'b0;
               rsp_enable_pin  <= 1'b0;
               rsp_data_nibble <= 4'd0;
               rsp_hold_ms     <= INIT_WAIT_MS;
            end else begin
               rsp_reg_select  <= src.reg_sel;
               rsp_enable_pin  <= (stp == 3'd1) || (stp == 3'd3);
               rsp_data_nibble <= (stp < 3'd3) ? src.byte_val[7:4] : src.byte_val[3:0];
               rsp_hold_ms     <= STEP_MS;
            end
         end
      end
   end

endmodule

// ===== rtl/char_lcd_nibble_write_sequencer.sv =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer
// Character LCD controller for a 4-bit bus: turns requests into timed pin
// snapshots (RS, E, D7..D4, hold time).
//
//   channel  direction  ports                      one transfer
//   req      in         req_valid / req_ready      one request
//   rsp      out        rsp_valid / rsp_ready      one pin snapshot
//
// The front end takes a request when idle, then pushes byte jobs
// into a four-entry queue: one job for a command, data or cursor move, seven
// for init, one per digit for a number. Each digit is converted by multiplying
// by the reciprocal of ten, then splitting off the remainder.
// The back end emits one snapshot per cycle while rsp_ready is high and a job
// is pending: five per byte, one for the 20 ms wait, up to fifty per request.
// Reset clears control state only; no clearing pass is needed.
// A stalled rsp side fills the queue and then holds the front end.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer import lcdw_pkg::*; #(
   parameter int MAX_DIGITS  = DEFAULT_MAX_DIGITS,
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic [7:0]  req_byte_value,
   input  logic [31:0] req_number_value,
   input  logic [1:0]  req_row_index,
   input  logic [5:0]  req_column_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_reg_select,
   output logic        rsp_enable_pin,
   output logic [3:0]  rsp_data_nibble,
   output logic [4:0]  rsp_hold_ms,
   output logic        rsp_last_flag
);

   logic         push_valid;
   job_type      push_data;
   job_type      head;
   logic         pop;
   q_status_type q_status;

   // Front end: classify requests, build digits, issue byte jobs
   lcdw_front #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_byte_value   (req_byte_value),
      .req_number_value (req_number_value),
      .req_row_index    (req_row_index),
      .req_column_index (req_column_index),
      .push_valid       (push_valid),
      .push_data        (push_data),
      .q_status         (q_status)
   );

   // Job queue: lets the front end run ahead of a stalled result side
   lcdw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .head       (head),
      .q_status   (q_status)
   );

   // Back end: expand each job into snapshots, hold them in the result register
   lcdw_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .q_status        (q_status),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_reg_select  (rsp_reg_select),
      .rsp_enable_pin  (rsp_enable_pin),
      .rsp_data_nibble (rsp_data_nibble),
      .rsp_hold_ms     (rsp_hold_ms),
      .rsp_last_flag   (rsp_last_flag)
   );

   // Never pop an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pop from empty job queue");

   // A request never ends on a snapshot with enable high
   a_last_enable_low: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_flag) |-> !rsp_enable_pin)
      else $error("last snapshot with enable high");

   // The 20 ms wait snapshot is all pins low and never ends a request
   a_wait_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_hold_ms == INIT_WAIT_MS)) |->
         (!rsp_enable_pin && !rsp_reg_select && (rsp_data_nibble == 4'd0)
          && !rsp_last_flag))
      else $error("malformed init wait snapshot");

   // Hold time is either one step or the init wait
   a_hold_values: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_hold_ms == STEP_MS) || (rsp_hold_ms == INIT_WAIT_MS)))
      else $error("unexpected hold time");

endmodule
